// ===== hdl/http_request_tokenizer_assert.svh =====
// Assertion macros shared by the tokenizer RTL files.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef HTTP_REQUEST_TOKENIZER_ASSERT_SVH
`define HTTP_REQUEST_TOKENIZER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle check: cond must hold at every clock edge out of reset.
`define HRT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Next-cycle check: when ante holds, cons must hold on the next clock edge.
`define HRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define HRT_ASSERT(lbl, cond, msg)
`define HRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/hrt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the HTTP request tokenizer.
// No dependencies; imported by every other RTL file.
package hrt_pkg;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_URI     = 3'd1,
    PH_VERSION = 3'd2,
    PH_HEADERS = 3'd3,
    PH_BODY    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_METHOD  = 3'd0,
    KIND_URI     = 3'd1,
    KIND_VERSION = 3'd2,
    KIND_HNAME   = 3'd3,
    KIND_HVALUE  = 3'd4,
    KIND_BODY    = 3'd5,
    KIND_SEP     = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_request;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] byte_kind;
    logic       tok_start;
    logic       header_invalid;
    logic       headers_done;
    logic       request_done;
  } out_item_t;

  typedef struct packed {
    logic is_sp;
    logic is_cr;
    logic is_lf;
    logic is_colon;
  } byte_class_t;

  typedef struct packed {
    in_item_t    item;
    byte_class_t cls;
  } q_entry_t;

endpackage

// ===== hdl/hrt_front.sv =====
`timescale 1ns / 1ps
// Front stage: accepts input bytes and registers them with their delimiter class.
// Depends on hrt_pkg.
module hrt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hrt_pkg::in_item_t in_data,
  output logic              f_valid,
  input  logic              f_ready,
  output hrt_pkg::q_entry_t f_data
);
  import hrt_pkg::*;

  logic        f_valid_r, f_valid_nxt;
  q_entry_t    f_data_r;
  byte_class_t cls;
  logic        take;

  always_comb begin
    cls.is_sp    = (in_data.data_byte == CH_SP);
    cls.is_cr    = (in_data.data_byte == CH_CR);
    cls.is_lf    = (in_data.data_byte == CH_LF);
    cls.is_colon = (in_data.data_byte == CH_COLON);
  end

  assign in_ready = !f_valid_r || f_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    if (take) begin
      f_valid_nxt = 1'b1;
    end else if (f_ready) begin
      f_valid_nxt = 1'b0;
    end else begin
      f_valid_nxt = f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_data_r <= '{item: in_data, cls: cls};
    end
  end

  assign f_valid = f_valid_r;
  assign f_data  = f_data_r;

endmodule

// ===== hdl/hrt_fifo.sv =====
`timescale 1ns / 1ps
// Short queue between the front and back stages of the tokenizer.
// Depends on hrt_pkg and the assertion macro header.
`include "http_request_tokenizer_assert.svh"
module hrt_fifo #(
  parameter int DEPTH = hrt_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  hrt_pkg::q_entry_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output hrt_pkg::q_entry_t rd_data
);
  import hrt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push, pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `HRT_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "queue fill count beyond depth")
  `HRT_ASSERT_NEXT(a_push_lands, push && !pop, count_r == $past(count_r) + CW'(1),
                   "queue push lost")

endmodule

// ===== hdl/hrt_back.sv =====
`timescale 1ns / 1ps
// Back stage: tokenizer state machine and registered result output.
// Depends on hrt_pkg and the assertion macro header.
`include "http_request_tokenizer_assert.svh"
module hrt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  hrt_pkg::q_entry_t  q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hrt_pkg::out_item_t out_data
);
  import hrt_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        prev_cr_r, prev_cr_nxt;
  logic        line_r, line_nxt;
  logic        colon_r, colon_nxt;
  logic        tok_r, tok_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r, res;
  byte_class_t cls;
  logic        take, pend, tok_eff;
  phase_t      ph_eff;
  kind_t       kind;
  logic        ts, inv, hd;

  assign cls     = q_data.cls;
  assign q_ready = !out_valid_r || out_ready;
  assign take    = q_valid && q_ready;

  // A CR in the request line not followed by LF splits when the next byte shows up.
  always_comb begin
    pend    = (phase_r == PH_METHOD || phase_r == PH_URI || phase_r == PH_VERSION) &&
              prev_cr_r && !cls.is_lf;
    ph_eff  = pend ? phase_t'(phase_r + 3'd1) : phase_r;
    tok_eff = pend ? 1'b0 : tok_r;
  end

  // Next state
  always_comb begin
    phase_nxt   = ph_eff;
    tok_nxt     = tok_eff;
    line_nxt    = line_r;
    colon_nxt   = colon_r;
    prev_cr_nxt = cls.is_cr;
    unique case (ph_eff)
      PH_METHOD, PH_URI, PH_VERSION: begin
        if (cls.is_cr) begin
          tok_nxt = 1'b0;
        end else if (cls.is_lf || cls.is_sp) begin
          phase_nxt = phase_t'(ph_eff + 3'd1);
          tok_nxt   = 1'b0;
        end else begin
          tok_nxt = 1'b1;
        end
      end
      PH_HEADERS: begin
        priority if (cls.is_cr) begin
          tok_nxt = 1'b0;
        end else if (cls.is_lf && prev_cr_r) begin
          if (!line_r) begin
            phase_nxt = PH_BODY;
          end
          line_nxt  = 1'b0;
          colon_nxt = 1'b0;
          tok_nxt   = 1'b0;
        end else if (!colon_r && cls.is_colon) begin
          colon_nxt = 1'b1;
          line_nxt  = 1'b1;
          tok_nxt   = 1'b0;
        end else if (!colon_r) begin
          tok_nxt  = 1'b1;
          line_nxt = 1'b1;
        end else if (cls.is_sp && !tok_eff) begin
          tok_nxt = tok_eff;
        end else begin
          tok_nxt = 1'b1;
        end
      end
      default: begin
        tok_nxt = 1'b1;
      end
    endcase
  end

  // Result fields
  always_comb begin
    kind = KIND_SEP;
    ts   = 1'b0;
    inv  = 1'b0;
    hd   = 1'b0;
    unique case (ph_eff)
      PH_METHOD, PH_URI, PH_VERSION: begin
        if (!(cls.is_cr || cls.is_lf || cls.is_sp)) begin
          kind = kind_t'(ph_eff);
          ts   = !tok_eff;
        end
      end
      PH_HEADERS: begin
        priority if (cls.is_cr) begin
          kind = KIND_SEP;
        end else if (cls.is_lf && prev_cr_r) begin
          inv = line_r && !colon_r;
          hd  = !line_r;
        end else if (!colon_r && cls.is_colon) begin
          kind = KIND_SEP;
        end else if (!colon_r) begin
          kind = KIND_HNAME;
          ts   = !tok_eff;
        end else if (cls.is_sp && !tok_eff) begin
          kind = KIND_SEP;
        end else begin
          kind = KIND_HVALUE;
          ts   = !tok_eff;
        end
      end
      default: begin
        kind = KIND_BODY;
        ts   = !tok_eff;
      end
    endcase
    res.out_byte       = q_data.item.data_byte;
    res.byte_kind      = kind;
    res.tok_start      = ts;
    res.header_invalid = inv;
    res.headers_done   = hd;
    res.request_done   = q_data.item.end_of_request;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_METHOD;
      prev_cr_r   <= 1'b0;
      line_r      <= 1'b0;
      colon_r     <= 1'b0;
      tok_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        if (q_data.item.end_of_request) begin
          phase_r   <= PH_METHOD;
          prev_cr_r <= 1'b0;
          line_r    <= 1'b0;
          colon_r   <= 1'b0;
          tok_r     <= 1'b0;
        end else begin
          phase_r   <= phase_nxt;
          prev_cr_r <= prev_cr_nxt;
          line_r    <= line_nxt;
          colon_r   <= colon_nxt;
          tok_r     <= tok_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `HRT_ASSERT_NEXT(a_eor_resets, take && q_data.item.end_of_request,
                   phase_r == PH_METHOD && !prev_cr_r && !tok_r && !line_r && !colon_r,
                   "state not cleared after end of request")
  `HRT_ASSERT(a_start_not_sep, !(out_valid_r && out_data_r.tok_start &&
              out_data_r.byte_kind == KIND_SEP), "token start on separator")
  `HRT_ASSERT(a_done_is_lf, !(out_valid_r && out_data_r.headers_done) ||
              (out_data_r.out_byte == CH_LF && !out_data_r.header_invalid),
              "headers done on wrong byte")
  `HRT_ASSERT_NEXT(a_body_after_done, take && hd && !q_data.item.end_of_request,
                   phase_r == PH_BODY, "body phase not entered after blank line")

endmodule

// ===== hdl/http_request_tokenizer.sv =====
`timescale 1ns / 1ps
// Top level of the HTTP request tokenizer: front stage, queue and back stage.
// Depends on hrt_pkg, hrt_front, hrt_fifo and hrt_back.
//
// Usage:
//   Input channel (in_valid / in_ready / in_data) carries one request byte per
//   transfer plus an end_of_request flag on the last byte of a request.
//   Output channel (out_valid / out_ready / out_data) returns exactly one
//   tagged byte per input transfer, in order: the byte, its kind (method,
//   URI, version, header name, header value, body, separator), token start,
//   header-invalid, headers-done and request-done flags.
//   Path: each input transfer passes the front register, the queue and the back
//   result register before out_valid rises. Throughput: one byte per cycle
//   while the receiver does not stall.
//   Reset (rst_n low, synchronous) empties all stages and puts the parser in
//   the method phase with no pending CR and no open token.
//   When the receiver stalls, the result register holds its transfer, the
//   queue fills, and in_ready drops only once front and queue are full.
module http_request_tokenizer #(
  parameter int QUEUE_DEPTH = hrt_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hrt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hrt_pkg::out_item_t out_data
);
  import hrt_pkg::*;

  // front -> queue
  logic     f_valid, f_ready;
  q_entry_t f_data;
  // queue -> back
  logic     q_valid, q_ready;
  q_entry_t q_data;

  // Front: registers the byte with its delimiter class (SP, CR, LF, colon).
  hrt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_data   (f_data)
  );

  // Queue: decouples classification from the parser so each can stall alone.
  hrt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  // Back: phase state machine, tags each byte and drives the result register.
  // A transfer flagged end_of_request returns the parser to the method phase.
  hrt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/http_request_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for http_request_tokenizer: drives request bytes, predicts each tag.
// Depends on hrt_pkg and the tokenizer RTL; needs no other file.
module http_request_tokenizer_tb;
  import hrt_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  http_request_tokenizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Tags still owed by the block, oldest first.
  out_item_t tag_queue[$];
  int        bad_count = 0;
  int        sent_count = 0;

  // Idle odds in percent, changed per test phase.
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // Byte string of the request being sent.
  logic [7:0] req_bytes[$];

  // ---------------------------------------------------------------------------
  // Parser state mirror. Mirrors the block's architectural state exactly; it
  // is updated once per accepted transfer, in acceptance order.
  // ---------------------------------------------------------------------------
  phase_t ps_phase;
  logic   ps_after_cr;      // last byte was CR
  logic   ps_line_content;  // current header line has content
  logic   ps_colon;         // current header line has had its colon
  logic   ps_in_token;      // previous byte was inside a token

  function automatic void clear_parse_state();
    ps_phase        = PH_METHOD;
    ps_after_cr     = 1'b0;
    ps_line_content = 1'b0;
    ps_colon        = 1'b0;
    ps_in_token     = 1'b0;
  endfunction

  // Tag one byte and advance the mirrored state.
  function automatic out_item_t tag_byte(input in_item_t it);
    logic [7:0] b;
    logic [2:0] ph;
    out_item_t  r;
    b = it.data_byte;
    ph = ps_phase;
    r.out_byte       = b;
    r.byte_kind      = KIND_SEP;
    r.tok_start      = 1'b0;
    r.header_invalid = 1'b0;
    r.headers_done   = 1'b0;
    r.request_done   = it.end_of_request;

    // A CR in the request line that is not followed by LF splits only now,
    // before the new byte is handled in the next phase.
    if (ph < PH_HEADERS && ps_after_cr && b != CH_LF) begin
      ph++;
      ps_in_token = 1'b0;
    end

    if (ph < PH_HEADERS) begin
      if (b == CH_CR) begin
        ps_in_token = 1'b0;
      end else if (b == CH_LF || b == CH_SP) begin
        // every separator advances, so tokens may be empty
        ph++;
        ps_in_token = 1'b0;
      end else begin
        r.byte_kind   = ph;  // method/uri/version share phase numbering
        r.tok_start   = !ps_in_token;
        ps_in_token   = 1'b1;
      end
    end else if (ph == PH_HEADERS) begin
      if (b == CH_CR) begin
        // lone CR: ends the token, not the line, not content
        ps_in_token = 1'b0;
      end else if (b == CH_LF && ps_after_cr) begin
        if (ps_line_content) begin
          r.header_invalid = !ps_colon;
        end else begin
          // blank line (or empty header block) ends the headers
          r.headers_done = 1'b1;
          ph = PH_BODY;
        end
        ps_line_content = 1'b0;
        ps_colon        = 1'b0;
        ps_in_token     = 1'b0;
      end else if (!ps_colon && b == CH_COLON) begin
        ps_colon        = 1'b1;
        ps_line_content = 1'b1;
        ps_in_token     = 1'b0;
      end else if (!ps_colon) begin
        // bare LF lands here too: ordinary name content
        r.byte_kind     = KIND_HNAME;
        r.tok_start     = !ps_in_token;
        ps_in_token     = 1'b1;
        ps_line_content = 1'b1;
      end else if (b == CH_SP && !ps_in_token) begin
        // leading space of a value stays a separator
      end else begin
        r.byte_kind   = KIND_HVALUE;
        r.tok_start   = !ps_in_token;
        ps_in_token   = 1'b1;
      end
    end else begin
      r.byte_kind   = KIND_BODY;
      r.tok_start   = !ps_in_token;
      ps_in_token   = 1'b1;
    end

    ps_phase    = phase_t'(ph);
    ps_after_cr = (b == CH_CR);
    if (it.end_of_request) clear_parse_state();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Called from anywhere; starts at the next falling edge and
  // returns at the rising edge of the transfer, so in_valid gets exactly one
  // assignment per falling edge (the next caller or wait_drain owns it).
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eor);
    in_item_t it;
    it.data_byte      = b;
    it.end_of_request = eor;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    tag_queue.push_back(tag_byte(it));
    sent_count++;
  endtask

  // Send req_bytes as one request, end_of_request on its last byte.
  task automatic send_request();
    for (int i = 0; i < req_bytes.size(); i++)
      send_byte(req_bytes[i], i == req_bytes.size() - 1);
  endtask

  // Hold off the sender until every owed tag has come back (bounded).
  task automatic wait_drain();
    int n;
    n = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (tag_queue.size() != 0 && n < 20000) begin
      @(negedge clk);
      n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall at random, check each transfer against the oldest tag.
  // ---------------------------------------------------------------------------
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tag_queue.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: unexpected transfer, got byte=%h kind=%0d", $time,
                   out_data.out_byte, out_data.byte_kind);
      end else begin
        want = tag_queue.pop_front();
        if (out_data !== want) begin
          bad_count++;
          if (bad_count <= 10)
            $display({"%0t: tag mismatch byte=%h: expected kind=%0d ts=%b inv=%b ",
                      "hd=%b rd=%b, got byte=%h kind=%0d ts=%b inv=%b hd=%b rd=%b"},
                     $time, want.out_byte, want.byte_kind, want.tok_start,
                     want.header_invalid, want.headers_done, want.request_done,
                     out_data.out_byte, out_data.byte_kind, out_data.tok_start,
                     out_data.header_invalid, out_data.headers_done,
                     out_data.request_done);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request builder for the random part.
  // ---------------------------------------------------------------------------
  // Token byte: never SP, CR, LF or colon; mostly printable.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do begin
      b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(33, 126));
    end while (b == CH_SP || b == CH_CR || b == CH_LF || b == CH_COLON);
    return b;
  endfunction

  // Header bytes may carry a lone CR (always followed by a non-LF byte).
  function automatic void add_token(input int n, input bit lone_cr);
    repeat (n) begin
      if (lone_cr && $urandom_range(23) == 0) req_bytes.push_back(CH_CR);
      req_bytes.push_back(text_byte());
    end
  endfunction

  function automatic void build_request();
    int pick;
    int cut;
    int r;
    req_bytes.delete();
    pick = $urandom_range(9);
    if (pick == 0) begin
      // noise: any bytes at all
      repeat ($urandom_range(1, 12)) req_bytes.push_back(8'($urandom_range(255)));
    end else begin
      add_token($urandom_range(0, 6), 1'b0);
      req_bytes.push_back(CH_SP);
      add_token($urandom_range(0, 8), 1'b0);
      req_bytes.push_back(CH_SP);
      add_token($urandom_range(0, 6), 1'b0);
      if ($urandom_range(7) != 0) req_bytes.push_back(CH_CR);
      req_bytes.push_back(CH_LF);
      repeat ($urandom_range(0, 4)) begin
        add_token($urandom_range(0, 6), 1'b1);
        if ($urandom_range(9) != 0) req_bytes.push_back(CH_COLON);
        repeat ($urandom_range(0, 2)) req_bytes.push_back(CH_SP);
        repeat ($urandom_range(0, 8)) begin
          r = $urandom_range(19);
          case (r)
            0: req_bytes.push_back(CH_COLON);
            1: req_bytes.push_back(CH_SP);
            2: req_bytes.push_back(CH_LF);
            3: begin
              req_bytes.push_back(CH_CR);
              req_bytes.push_back(text_byte());
            end
            default: req_bytes.push_back(text_byte());
          endcase
        end
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
      end
      req_bytes.push_back(CH_CR);
      req_bytes.push_back(CH_LF);
      repeat ($urandom_range(0, 8)) req_bytes.push_back(8'($urandom_range(255)));
      // broken request: cut short, end flag lands mid-way
      if (pick == 1) begin
        cut = $urandom_range(0, req_bytes.size() - 2);
        req_bytes = req_bytes[0:cut];
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Extreme bytes, back-to-back spaces (empty URI), and a CR in the version
  // not followed by LF: the next byte is handled as a header name. The end
  // flag lands in the middle of a header name.
  task automatic test_request_line_splits();
    req_bytes = '{8'h00, CH_SP, CH_SP, 8'hFF, CH_CR, "k"};
    send_request();
  endtask

  // Empty request-line tokens via LFs, lone CR inside a name, skipped value
  // spaces, second colon in a value, bare LF in a value, a line without a
  // colon, a colon-only line, then the blank line and one body byte.
  task automatic test_header_lines();
    req_bytes = '{CH_LF, CH_LF, CH_LF, "k", CH_CR, CH_COLON, CH_SP, "a", CH_COLON,
                  CH_LF, CH_CR, CH_LF, "q", CH_CR, CH_LF, CH_COLON, CH_CR, CH_LF,
                  CH_CR, CH_LF, 8'hFF};
    send_request();
  endtask

  // CRLF straight after the request line ends the headers at once. The sender
  // first waits until the block has emptied out.
  task automatic test_empty_header_block();
    wait_drain();
    req_bytes = '{"G", CH_SP, CH_SP, CH_CR, CH_LF, CH_CR, CH_LF, 8'h80};
    send_request();
  endtask

  // Mostly well-formed requests with random content, some cut short, some
  // noise; now and then the sender pauses until everything is back.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_bytes);
    int target;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target = sent_count + n_bytes;
    while (sent_count < target) begin
      build_request();
      send_request();
      if ($urandom_range(15) == 0) wait_drain();
    end
  endtask

  initial begin
    clear_parse_state();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_request_line_splits();
    test_header_lines();
    test_empty_header_block();
    test_random_traffic(0, 0, 430);
    test_random_traffic(79, 0, 430);
    test_random_traffic(0, 79, 430);
    test_random_traffic(16, 16, 430);

    // drain, then give the three-stage pipe time to show any stray transfer
    wait_drain();
    repeat (12) @(negedge clk);
    if (tag_queue.size() != 0) begin
      bad_count += tag_queue.size();
      $display("%0d tags never arrived", tag_queue.size());
    end
    if (bad_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
